>>> rtl/g711_pkg.sv
// Shared types and constants for the G.711 companding codec.
// Depends on nothing; the stage modules and the top level import it.
`timescale 1ns / 1ps

package g711_pkg;

  localparam logic CmdEncode = 1'b0;
  localparam logic CmdDecode = 1'b1;

  localparam logic LawMu = 1'b0;
  localparam logic LawA  = 1'b1;

  localparam logic [15:0] MuBias    = 16'd132;
  localparam logic [15:0] ABias     = 16'd8;
  localparam logic [14:0] MagMax    = 15'h7FFF;
  localparam logic [15:0] MostNeg   = 16'h8000;
  localparam logic [6:0]  AXorMask  = 7'h55;
  localparam logic [7:0]  AXorCode  = 8'h55;
  localparam logic [8:0]  ASegBase  = 9'h108;
  localparam logic [7:0]  MuBase    = 8'd132;
  localparam logic [7:0]  ASeg0Bias = 8'd8;

  // Stage 1 result: biased, clipped magnitude for encode; code fields for decode.
  typedef struct packed {
    logic        cmd;
    logic        neg;
    logic [14:0] adj;
    logic [2:0]  seg;
    logic [3:0]  mant;
  } g711_s1_t;

  // Stage 2 result: segment and mantissa for encode; shifted magnitude for decode.
  typedef struct packed {
    logic        cmd;
    logic        neg;
    logic [2:0]  seg;
    logic [3:0]  mant;
    logic [14:0] dmag;
  } g711_s2_t;

  typedef struct packed {
    logic [7:0]        code_out;
    logic signed [15:0] linear_out;
  } g711_res_t;

endpackage

>>> rtl/g711_if.sv
// Handshake channel interfaces of the G.711 codec: input, result and config.
// Depends on nothing.
`timescale 1ns / 1ps

interface g711_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] linear_in;
  logic [7:0]         code_in;
  modport source (output valid, output cmd, output linear_in, output code_in, input ready);
  modport sink   (input valid, input cmd, input linear_in, input code_in, output ready);
endinterface

interface g711_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         code_out;
  logic signed [15:0] linear_out;
  modport source (output valid, output code_out, output linear_out, input ready);
  modport sink   (input valid, input code_out, input linear_out, output ready);
endinterface

interface g711_cfg_if;
  logic valid;
  logic ready;
  logic law_select;
  modport source (output valid, output law_select, input ready);
  modport sink   (input valid, input law_select, output ready);
endinterface

>>> rtl/g711_mag_stage.sv
// Pipeline stage 1: sign and biased, clipped magnitude for encode; code unpack
// for decode. Depends on g711_pkg.
`timescale 1ns / 1ps

module g711_mag_stage import g711_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               law_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic               cmd_i,
  input  logic signed [15:0] linear_i,
  input  logic [7:0]         code_i,
  output logic               valid_o,
  input  logic               ready_i,
  output g711_s1_t           data_o
);

  logic        valid_q;
  g711_s1_t    data_q, data_d;
  logic [15:0] neg_lin;
  logic [14:0] mag;
  logic [15:0] sum;
  logic [7:0]  ucode;

  always_comb begin
    neg_lin = 16'd0 - linear_i;
    if (!linear_i[15]) begin
      mag = linear_i[14:0];
    end else if (linear_i == MostNeg) begin
      mag = MagMax;
    end else begin
      mag = neg_lin[14:0];
    end
    sum = {1'b0, mag} + ((law_i == LawA) ? ABias : MuBias);

    ucode = (law_i == LawA) ? (code_i ^ AXorCode) : ~code_i;

    data_d.cmd  = cmd_i;
    data_d.adj  = sum[15] ? MagMax : sum[14:0];
    data_d.seg  = ucode[6:4];
    data_d.mant = ucode[3:0];
    if (cmd_i == CmdEncode) begin
      data_d.neg = linear_i[15];
    end else begin
      // Both laws mark negatives with bit 7 of the code byte clear.
      data_d.neg = (law_i == LawA) ? ~ucode[7] : ucode[7];
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

>>> rtl/g711_seg_stage.sv
// Pipeline stage 2: leading-one segment search and mantissa extraction for
// encode; segment shift of the interval base for decode. Depends on g711_pkg.
`timescale 1ns / 1ps

module g711_seg_stage import g711_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     law_i,
  input  logic     valid_i,
  output logic     ready_o,
  input  g711_s1_t data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output g711_s2_t data_o
);

  logic        valid_q;
  g711_s2_t    data_q, data_d;
  logic [2:0]  eseg;
  logic [3:0]  eshift;
  logic [14:0] shifted;
  logic [7:0]  mu_base;
  logic [8:0]  a_base;

  always_comb begin
    // Both laws take the segment as the bit length of adj[14:8].
    eseg = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (data_i.adj[8 + i]) begin
        eseg = 3'(i + 1);
      end
    end
    if ((law_i == LawA) && (eseg == 3'd0)) begin
      eshift = 4'd4;
    end else begin
      eshift = {1'b0, eseg} + 4'd3;
    end
    shifted = data_i.adj >> eshift;

    mu_base = {1'b0, data_i.mant, 3'b000} + MuBase;
    a_base  = {1'b0, data_i.mant, 4'b0000} + ASegBase;

    data_d.cmd = data_i.cmd;
    data_d.neg = data_i.neg;
    if (data_i.cmd == CmdEncode) begin
      data_d.seg  = eseg;
      data_d.mant = shifted[3:0];
    end else begin
      data_d.seg  = data_i.seg;
      data_d.mant = data_i.mant;
    end
    if (law_i == LawMu) begin
      data_d.dmag = {7'd0, mu_base} << data_i.seg;
    end else if (data_i.seg == 3'd0) begin
      data_d.dmag = {7'd0, data_i.mant, 4'b0000} + {7'd0, ASeg0Bias};
    end else begin
      data_d.dmag = {6'd0, a_base} << (data_i.seg - 3'd1);
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

>>> rtl/g711_pack_stage.sv
// Pipeline stage 3 and output register: code byte packing for encode, mu-law bias
// removal and sign for decode. Depends on g711_pkg.
`timescale 1ns / 1ps

module g711_pack_stage import g711_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      law_i,
  input  logic      valid_i,
  output logic      ready_o,
  input  g711_s2_t  data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output g711_res_t data_o
);

  logic        valid_q;
  g711_res_t   data_q, data_d;
  logic [15:0] wide;
  logic [15:0] dec;

  always_comb begin
    wide = {1'b0, data_i.dmag};
    if (law_i == LawMu) begin
      dec = data_i.neg ? (MuBias - wide) : (wide - MuBias);
    end else begin
      dec = data_i.neg ? (16'd0 - wide) : wide;
    end

    data_d.code_out   = 8'd0;
    data_d.linear_out = 16'sd0;
    if (data_i.cmd == CmdEncode) begin
      if (law_i == LawMu) begin
        data_d.code_out = ~{data_i.neg, data_i.seg, data_i.mant};
      end else begin
        data_d.code_out = {~data_i.neg, {data_i.seg, data_i.mant} ^ AXorMask};
      end
    end else begin
      data_d.linear_out = signed'(dec);
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

>>> rtl/g711_companding_codec.sv
// Top level of the G.711 mu-law / A-law codec: law register and three-stage
// pipeline. Depends on g711_pkg, g711_if and the three stage modules.
`timescale 1ns / 1ps

// G.711 compander. Each beat on in_i either encodes a signed 16-bit sample
// (cmd 0) into a code byte or decodes a code byte (cmd 1) into a sample; the
// unused output field of a result reads zero. The law (0 mu-law, 1 A-law)
// comes from a one-bit register written on cfg_i, which is always ready and
// resets to mu-law; write it only while no beats are in flight. The datapath
// is a three-stage pipeline (magnitude and bias, segment search, packing)
// whose last stage is the output register; a beat passes through the stage 1
// and 2 registers into it, and one beat is taken every cycle while out_o is
// ready. When out_o stalls, the empty stages ahead of the output still fill,
// and in_i drops ready only once all three stages hold a beat.
module g711_companding_codec import g711_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  g711_in_if.sink     in_i,
  g711_out_if.source  out_o,
  g711_cfg_if.sink    cfg_i
);

  logic      law_q;
  logic      v1, v2, r1, r2, r3;
  g711_s1_t  s1;
  g711_s2_t  s2;
  g711_res_t res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      law_q <= LawMu;
    end else if (cfg_i.valid) begin
      law_q <= cfg_i.law_select;
    end
  end

  g711_mag_stage u_mag (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .law_i    (law_q),
    .valid_i  (in_i.valid),
    .ready_o  (r1),
    .cmd_i    (in_i.cmd),
    .linear_i (in_i.linear_in),
    .code_i   (in_i.code_in),
    .valid_o  (v1),
    .ready_i  (r2),
    .data_o   (s1)
  );

  g711_seg_stage u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .law_i   (law_q),
    .valid_i (v1),
    .ready_o (r2),
    .data_i  (s1),
    .valid_o (v2),
    .ready_i (r3),
    .data_o  (s2)
  );

  g711_pack_stage u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .law_i   (law_q),
    .valid_i (v2),
    .ready_o (r3),
    .data_i  (s2),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (res)
  );

  assign in_i.ready       = r1;
  assign out_o.code_out   = res.code_out;
  assign out_o.linear_out = res.linear_out;

  // Input backs up only when every stage holds a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1 && v2 && out_o.valid))
    else $error("input stalled while the pipeline has room");

  // An accepted beat lands in stage 1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1)
    else $error("accepted beat lost at stage 1");

  // A beat waiting in stage 2 moves to the output or stays; it never vanishes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2 |=> (out_o.valid && $past(r3)) || v2)
    else $error("stage 2 beat dropped");

endmodule
